// ===== hdl/fpba_pkg.sv =====
// Shared constants, codes and types of the fit policy block allocator.
package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int BLOCKS_RST = (NUM_BLOCKS < 16) ? NUM_BLOCKS : 16;

  localparam int MODE_W     = 2;
  localparam int BIDX_W     = 4;
  localparam int SVAL_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REQ     = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_GRANT   = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef struct packed {
    policy_t            policy;
    logic [CNT_W-1:0]   count;
  } cfg_t;

endpackage

// ===== hdl/fpba_if.sv =====
// Word channel interfaces for the allocator's input and result sides.
interface fpba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  block_index;
  logic [15:0] size_value;

  modport source (output valid, mode, block_index, size_value, input ready);
  modport sink   (input valid, mode, block_index, size_value, output ready);
endinterface

interface fpba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_block;
  logic [15:0] left_in_block;

  modport source (output valid, status, chosen_block, left_in_block, input ready);
  modport sink   (input valid, status, chosen_block, left_in_block, output ready);
endinterface

// ===== hdl/fpba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fpba_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fpba_cfg.sv =====
// Configuration registers: placement policy and saturated block count.
module fpba_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output fpba_pkg::cfg_t                   cfg
);

  fpba_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy <= fpba_pkg::POL_FIRST;
      cfg_r.count  <= fpba_pkg::CNT_W'(fpba_pkg::BLOCKS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpba_pkg::REG_POLICY: begin
          cfg_r.policy <= fpba_pkg::policy_t'(cfg_wdata[1:0]);
        end
        fpba_pkg::REG_BLOCKS: begin
          if (int'(cfg_wdata) > fpba_pkg::NUM_BLOCKS) begin
            cfg_r.count <= fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS);
          end else begin
            cfg_r.count <= fpba_pkg::CNT_W'(cfg_wdata);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/fpba_engine.sv =====
// Sequencer that loads, scans, restores and updates the capacity memories.
module fpba_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fpba_pkg::cfg_t                     cfg,
  fpba_in_if.sink                            in_ch,
  fpba_out_if.source                         out_ch,
  output logic                               fr_we,
  output logic [fpba_pkg::IDX_W-1:0]         fr_waddr,
  output logic [fpba_pkg::SIZE_BITS-1:0]     fr_wdata,
  output logic [fpba_pkg::IDX_W-1:0]         fr_raddr,
  input  logic [fpba_pkg::SIZE_BITS-1:0]     fr_rdata,
  output logic                               ld_we,
  output logic [fpba_pkg::IDX_W-1:0]         ld_waddr,
  output logic [fpba_pkg::SIZE_BITS-1:0]     ld_wdata,
  output logic [fpba_pkg::IDX_W-1:0]         ld_raddr,
  input  logic [fpba_pkg::SIZE_BITS-1:0]     ld_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESTORE,
    S_RESP
  } state_t;

  state_t                            state_r;
  logic [fpba_pkg::CNT_W-1:0]        iss_r;
  logic                              rd_vld_r;
  logic [fpba_pkg::IDX_W-1:0]        rd_idx_r;
  logic [fpba_pkg::SIZE_BITS-1:0]    req_r;
  logic                              have_r;
  logic [fpba_pkg::IDX_W-1:0]        pick_idx_r;
  logic [fpba_pkg::SIZE_BITS-1:0]    pick_cap_r;
  logic                              stop_r;
  fpba_pkg::status_t                 res_status_r;
  logic [fpba_pkg::IDX_W-1:0]        res_chosen_r;
  logic [fpba_pkg::SIZE_BITS-1:0]    res_left_r;
  logic                              out_valid_r;
  fpba_pkg::status_t                 out_status_r;
  logic [fpba_pkg::IDX_W-1:0]        out_chosen_r;
  logic [fpba_pkg::SIZE_BITS-1:0]    out_left_r;

  logic                              accept;
  fpba_pkg::mode_t                   in_mode;
  logic [fpba_pkg::SIZE_BITS-1:0]    in_size;
  logic                              load_we;
  logic [fpba_pkg::CNT_W-1:0]        limit;
  logic                              issue;
  logic                              sweep_end;
  logic                              take;
  logic                              fit;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign in_mode       = fpba_pkg::mode_t'(in_ch.mode);
  assign in_size       = fpba_pkg::SIZE_BITS'(in_ch.size_value);
  assign load_we       = accept && (in_mode == fpba_pkg::MODE_LOAD) &&
                         (int'(in_ch.block_index) < fpba_pkg::NUM_BLOCKS);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.chosen_block  = 4'(out_chosen_r);
  assign out_ch.left_in_block = 16'(out_left_r);

  assign limit     = (state_r == S_SCAN) ? cfg.count : fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS);
  assign issue     = ((state_r == S_SCAN) || (state_r == S_RESTORE)) && (iss_r < limit);
  assign sweep_end = (iss_r == limit) && !rd_vld_r;

  assign fr_raddr = iss_r[fpba_pkg::IDX_W-1:0];
  assign ld_raddr = iss_r[fpba_pkg::IDX_W-1:0];

  assign ld_we    = load_we;
  assign ld_waddr = fpba_pkg::IDX_W'(in_ch.block_index);
  assign ld_wdata = in_size;

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = fpba_pkg::IDX_W'(in_ch.block_index);
    fr_wdata = in_size;
    if (load_we) begin
      fr_we = 1'b1;
    end else if ((state_r == S_RESTORE) && rd_vld_r) begin
      fr_we    = 1'b1;
      fr_waddr = rd_idx_r;
      fr_wdata = ld_rdata;
    end else if ((state_r == S_RESP) && (res_status_r == fpba_pkg::ST_GRANT)) begin
      fr_we    = 1'b1;
      fr_waddr = res_chosen_r;
      fr_wdata = res_left_r;
    end
  end

  always_comb begin
    unique case (cfg.policy)
      fpba_pkg::POL_BEST: begin
        take = (req_r <= fr_rdata) && (!have_r || (fr_rdata < pick_cap_r));
      end
      fpba_pkg::POL_WORST: begin
        take = !have_r || (fr_rdata > pick_cap_r);
      end
      default: begin
        take = (req_r <= fr_rdata) && !have_r;
      end
    endcase
    fit = have_r && ((cfg.policy != fpba_pkg::POL_WORST) || (req_r <= pick_cap_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= issue;
      if (issue) begin
        iss_r    <= iss_r + 1'b1;
        rd_idx_r <= iss_r[fpba_pkg::IDX_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          res_status_r <= fpba_pkg::ST_DONE;
          res_chosen_r <= '0;
          res_left_r   <= '0;
          iss_r        <= '0;
          have_r       <= 1'b0;
          req_r        <= in_size;
          if (accept) begin
            unique case (in_mode)
              fpba_pkg::MODE_REQ: begin
                if (stop_r) begin
                  res_status_r <= fpba_pkg::ST_REFUSED;
                  state_r      <= S_RESP;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              fpba_pkg::MODE_RESTORE: begin
                state_r <= S_RESTORE;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_vld_r && take) begin
            have_r     <= 1'b1;
            pick_idx_r <= rd_idx_r;
            pick_cap_r <= fr_rdata;
          end
          if (sweep_end) begin
            if (fit) begin
              res_status_r <= fpba_pkg::ST_GRANT;
              res_chosen_r <= pick_idx_r;
              res_left_r   <= pick_cap_r - req_r;
            end else begin
              res_status_r <= fpba_pkg::ST_NOFIT;
              stop_r       <= 1'b1;
            end
            state_r <= S_RESP;
          end
        end
        S_RESTORE: begin
          if (sweep_end) begin
            stop_r  <= 1'b0;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_chosen_r <= res_chosen_r;
            out_left_r   <= res_left_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS))
    else $error("Sweep counter ran past the table.");

  a_dual_write_load: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_we && ld_we) |-> (state_r == S_IDLE))
    else $error("Both tables written outside a load.");

  a_stop_on_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stop_r) |-> (res_status_r == fpba_pkg::ST_NOFIT))
    else $error("Stop flag set without a failed request.");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ((state_r == S_SCAN) || (state_r == S_RESTORE)))
    else $error("Memory read word pending outside a sweep.");
`endif

endmodule

// ===== hdl/fit_policy_block_allocator_top.sv =====
// Top level of the fit policy block allocator.
// Each input word is handled on its own. A load, a refused request or an unused mode goes from
// the idle state straight to the result state. A searched request reads blocks_in_use entries
// of the free capacity memory, one entry per cycle through its single read port, and the last
// read word is checked before the result is formed. A restore copies NUM_BLOCKS entries, one
// entry per cycle, from the loaded size memory. The result appears in the same cycle in which
// the next word can be accepted. A finished result waits in the output register while the next
// word is accepted; while the receiver stalls, the result after it is held back and no further
// word is accepted.
module fit_policy_block_allocator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  fpba_in_if.sink                          in_ch,
  fpba_out_if.source                       out_ch
);

  fpba_pkg::cfg_t                      cfg;
  logic                                fr_we;
  logic [fpba_pkg::IDX_W-1:0]          fr_waddr;
  logic [fpba_pkg::SIZE_BITS-1:0]      fr_wdata;
  logic [fpba_pkg::IDX_W-1:0]          fr_raddr;
  logic [fpba_pkg::SIZE_BITS-1:0]      fr_rdata;
  logic                                ld_we;
  logic [fpba_pkg::IDX_W-1:0]          ld_waddr;
  logic [fpba_pkg::SIZE_BITS-1:0]      ld_wdata;
  logic [fpba_pkg::IDX_W-1:0]          ld_raddr;
  logic [fpba_pkg::SIZE_BITS-1:0]      ld_rdata;

  fpba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpba_ram #(
    .DEPTH (fpba_pkg::NUM_BLOCKS),
    .WIDTH (fpba_pkg::SIZE_BITS)
  ) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  fpba_ram #(
    .DEPTH (fpba_pkg::NUM_BLOCKS),
    .WIDTH (fpba_pkg::SIZE_BITS)
  ) u_loaded_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (ld_raddr),
    .rdata (ld_rdata)
  );

  fpba_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .fr_we    (fr_we),
    .fr_waddr (fr_waddr),
    .fr_wdata (fr_wdata),
    .fr_raddr (fr_raddr),
    .fr_rdata (fr_rdata),
    .ld_we    (ld_we),
    .ld_waddr (ld_waddr),
    .ld_wdata (ld_wdata),
    .ld_raddr (ld_raddr),
    .ld_rdata (ld_rdata)
  );

endmodule

// ===== tb/sv/fpba_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the allocator's result words.
package fpba_tb_pkg;
  import fpba_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [BIDX_W-1:0]      chosen;
    logic [SIZE_BITS-1:0]   left;
  } answer_t;

  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] free_cap [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] loaded [NUM_BLOCKS];
    bit                   stopped;
    logic [1:0]           policy;
    logic [4:0]           blocks;
    answer_t              awaited_answers [$];
    int unsigned          mismatches;

    function new();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        free_cap[i] = '0;
        loaded[i] = '0;
      end
      stopped = 1'b0;
      policy = POL_FIRST;
      blocks = 5'd16;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_POLICY) begin
        policy = data[1:0];
      end else begin
        blocks = data;
      end
    endfunction

    function int searched_blocks();
      return (blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks);
    endfunction

    function logic [SIZE_BITS-1:0] capacity_of(int i);
      return free_cap[i];
    endfunction

    function bit is_stopped();
      return stopped;
    endfunction

    function int outstanding();
      return awaited_answers.size();
    endfunction

    // Returns the block that takes the request, or -1 when none does.
    function int place_request(logic [SIZE_BITS-1:0] req);
      int count;
      int pick;
      count = searched_blocks();
      pick = -1;
      if (policy == POL_BEST) begin
        for (int j = 0; j < count; j++) begin
          if (req <= free_cap[j] && (pick < 0 || free_cap[j] < free_cap[pick])) begin
            pick = j;
          end
        end
      end else if (policy == POL_WORST) begin
        if (count > 0) begin
          pick = 0;
          for (int j = 1; j < count; j++) begin
            if (free_cap[j] > free_cap[pick]) begin
              pick = j;
            end
          end
          if (req > free_cap[pick]) begin
            pick = -1;
          end
        end
      end else begin
        for (int j = 0; j < count; j++) begin
          if (pick < 0 && req <= free_cap[j]) begin
            pick = j;
          end
        end
      end
      return pick;
    endfunction

    function answer_t predict_answer(logic [MODE_W-1:0] mode, logic [BIDX_W-1:0] idx,
                                     logic [SVAL_W-1:0] size);
      answer_t a;
      int pick;
      a.status = ST_DONE;
      a.chosen = '0;
      a.left = '0;
      case (mode)
        MODE_LOAD: begin
          free_cap[idx] = size;
          loaded[idx] = size;
        end
        MODE_RESTORE: begin
          for (int i = 0; i < NUM_BLOCKS; i++) begin
            free_cap[i] = loaded[i];
          end
          stopped = 1'b0;
        end
        MODE_REQ: begin
          if (stopped) begin
            a.status = ST_REFUSED;
          end else begin
            pick = place_request(size);
            if (pick < 0) begin
              a.status = ST_NOFIT;
              stopped = 1'b1;
            end else begin
              free_cap[pick] = free_cap[pick] - size;
              a.status = ST_GRANT;
              a.chosen = pick[BIDX_W-1:0];
              a.left = free_cap[pick];
            end
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_word(logic [MODE_W-1:0] mode, logic [BIDX_W-1:0] idx,
                            logic [SVAL_W-1:0] size);
      awaited_answers.push_back(predict_answer(mode, idx, size));
    endfunction

    function void check_word(logic [STATUS_W-1:0] status, logic [BIDX_W-1:0] chosen,
                             logic [SIZE_BITS-1:0] left);
      answer_t want;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result word: status %0d block %0d left %0d",
                   status, chosen, left);
        end
        return;
      end
      want = awaited_answers.pop_front();
      if (status !== want.status || chosen !== want.chosen || left !== want.left) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected status %0d block %0d left %0d, got status %0d block %0d left %0d",
                   want.status, want.chosen, want.left, status, chosen, left);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/fit_policy_block_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fit policy block allocator with directed and random words.
module fit_policy_block_allocator_top_tb;
  import fpba_pkg::*;
  import fpba_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 16;
  localparam int WORDS_PER_PHASE = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fpba_in_if  in_ch ();
  fpba_out_if out_ch ();

  fit_policy_block_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  alloc_scoreboard sb = new();
  int unsigned     burst_left = 0;
  int unsigned     quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.status, out_ch.chosen_block, out_ch.left_in_block);
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // The receiver switches between always ready, coin-flip and long stall runs.
  initial begin
    int   rx_style;
    int   rx_age;
    int   rx_run;
    logic rx_level;
    rx_style = 0;
    rx_age = 0;
    rx_run = 0;
    rx_level = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_age == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_age = $urandom_range(100, 400);
      end
      rx_age--;
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (rx_style == 0) begin
        out_ch.ready <= 1'b1;
      end else if (rx_style == 1) begin
        out_ch.ready <= $urandom_range(0, 1);
      end else begin
        if (rx_run == 0) begin
          rx_level = !rx_level;
          rx_run = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 40);
        end
        rx_run--;
        out_ch.ready <= rx_level;
      end
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [BIDX_W-1:0] idx,
                           input logic [SVAL_W-1:0] size);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= 2'($urandom_range(0, 3));
      in_ch.size_value <= 16'($urandom_range(0, 65535));
      repeat ($urandom_range(1, 25)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.block_index <= idx;
    in_ch.size_value <= size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(mode, idx, size);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic reprogram(input logic [CFG_DATA_W-1:0] policy_word,
                           input logic [CFG_DATA_W-1:0] count_word);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_wdata <= policy_word;
    @(posedge clk);
    sb.set_register(REG_POLICY, policy_word);
    @(negedge clk);
    cfg_index <= REG_BLOCKS;
    cfg_wdata <= count_word;
    @(posedge clk);
    sb.set_register(REG_BLOCKS, count_word);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int                r;
    int                k;
    int                count;
    logic [SVAL_W-1:0] size;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    count = sb.searched_blocks();
    if (r < 6 || (sb.is_stopped() && r < 35)) begin
      send_word(MODE_RESTORE, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    end else if (r < 20) begin
      if (k < 4) begin
        size = 16'(500 * $urandom_range(0, 16));
      end else if (k < 8) begin
        size = 16'($urandom_range(0, 65535));
      end else begin
        size = (k == 8) ? 16'h0000 : 16'hFFFF;
      end
      send_word(MODE_LOAD, 4'($urandom_range(0, 15)), size);
    end else if (r < 23) begin
      send_word(MODE_SPARE, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    end else begin
      if (k < 5) begin
        size = 16'($urandom_range(0, 2000));
      end else if (k < 8 && count > 0) begin
        size = sb.capacity_of($urandom_range(0, count - 1));
        if (k == 7) begin
          size = size + 16'd1;
        end
      end else if (k == 9) begin
        size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else begin
        size = 16'($urandom_range(0, 65535));
      end
      send_word(MODE_REQ, 4'($urandom_range(0, 15)), size);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] count_word;
    int                    c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.block_index = '0;
    in_ch.size_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every block is loaded first, so no search or restore ever reads an unwritten entry.
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (i == 7 || i == 9) begin
        send_word(MODE_LOAD, 4'(i), 16'h5000);
      end else begin
        send_word(MODE_LOAD, 4'(i), (i == 15) ? 16'hFFFF : 16'(16'h1111 * i));
      end
    end
    send_word(MODE_SPARE, 4'hF, 16'hFFFF);
    send_word(MODE_REQ, 4'h0, 16'h0000);
    send_word(MODE_REQ, 4'h0, 16'hFFFF);
    send_word(MODE_REQ, 4'h0, 16'hFFFF);
    send_word(MODE_REQ, 4'h0, 16'h0001);
    send_word(MODE_LOAD, 4'hF, 16'hFFFF);
    send_word(MODE_RESTORE, 4'h0, 16'h0000);
    send_word(MODE_REQ, 4'h0, 16'h2000);

    reprogram(5'b11101, 5'd31);
    send_word(MODE_REQ, 4'h0, 16'h5000);
    send_word(MODE_REQ, 4'h0, 16'h0001);
    reprogram(5'b00010, 5'd0);
    send_word(MODE_REQ, 4'h0, 16'h0000);
    send_word(MODE_RESTORE, 4'h0, 16'h0000);
    reprogram(5'b00011, 5'd1);
    send_word(MODE_REQ, 4'h0, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      c = $urandom_range(0, 9);
      if (c == 0) begin
        count_word = 5'd0;
      end else if (c == 1) begin
        count_word = 5'd16;
      end else if (c == 2) begin
        count_word = 5'($urandom_range(17, 31));
      end else begin
        count_word = 5'($urandom_range(1, 16));
      end
      reprogram(5'($urandom_range(0, 31)), count_word);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          drain();
        end
        random_word();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
